// ----- hdl/sts_pkg.sv -----
`default_nettype none

package sts_pkg;

  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned LINE_W   = 20;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned TAB_W    = 5;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(4);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [0:0] REG_TAB_STEP = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  typedef struct packed {
    logic       op;
    logic [7:0] source_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [OFFSET_W-1:0] start_offset;
    logic [OFFSET_W-1:0] end_offset;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    column;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } lex_res_t;

  function automatic logic is_alnum(input logic [7:0] b);
    is_alnum = (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UZ) ||
               (b >= CH_LA && b <= CH_LZ);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    is_punct = (b == CH_LPAR) || (b == CH_RPAR) || (b == CH_SEMI) || (b == CH_LBRC) ||
               (b == CH_RBRC) || (b == CH_COMMA) || (b == CH_PLUS) || (b == CH_MINUS) ||
               (b == CH_STAR) || (b == CH_SLASH) || (b == CH_PCT) || (b == CH_EQ);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/source_token_splitter.sv -----
`default_nettype none

// Source token splitter. Takes one source byte per cycle unless in_stall is
// high and emits one token transaction (start/end offset, line, column) when
// a token closes; an end transaction flushes the open token or reports
// end/empty source and restarts all counters. An accepted byte passes the input
// register, then the lexer state update loading the output register, where
// out_valid rises; a stalled output can hold the item in the input register.
// Throughput is one transaction per cycle while the output is not stalled.
// The tab step register sits at APB address 0 (5 bits, reset 4); write it
// only when idle.

module source_token_splitter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire sts_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output sts_pkg::out_item_t                out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sts_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sts_pkg::APB_DW-1:0]   pwdata,
  output logic [sts_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic                        fire;
  logic                        down_free;
  sts_pkg::in_item_t           item;
  sts_pkg::lex_res_t           res;
  logic [sts_pkg::TAB_W-1:0]   tab_r;
  logic [sts_pkg::TAB_W-1:0]   tab_nxt;
  logic                        reg_sel;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[sts_pkg::APB_AW-1:2] == sts_pkg::REG_TAB_STEP);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;
  assign tab_nxt = wr_en ? pwdata[sts_pkg::TAB_W-1:0] : tab_r;
  assign prdata  = reg_sel ? {{(sts_pkg::APB_DW - sts_pkg::TAB_W){1'b0}}, tab_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_r <= sts_pkg::TAB_RESET;
    end else begin
      tab_r <= tab_nxt;
    end
  end

  sts_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .down_free (down_free),
    .fire      (fire),
    .item      (item)
  );

  sts_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .tab_step  (tab_r),
    .res       (res)
  );

  sts_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .up_free   (down_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.op == sts_pkg::OP_END) |=> (out_valid && out_data.last))
    else $error("end transaction did not produce a last result");

  a_nontoken_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != sts_pkg::KIND_TOKEN) |-> out_data.last)
    else $error("end or empty result without last");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_result_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> down_free)
    else $error("result produced with output register occupied");

endmodule

`default_nettype wire

// ----- hdl/sts_in_stage.sv -----
`default_nettype none

module sts_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sts_pkg::in_item_t in_data,
  input  wire logic             down_free,
  output logic                  fire,
  output sts_pkg::in_item_t     item
);

  logic              valid_r;
  logic              valid_nxt;
  sts_pkg::in_item_t item_r;
  logic              load;

  assign in_stall  = valid_r && !down_free;
  assign fire      = valid_r && down_free;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !fire);
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sts_lexer.sv -----
`default_nettype none

module sts_lexer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire sts_pkg::in_item_t              item,
  input  wire logic [sts_pkg::TAB_W-1:0]      tab_step,
  output sts_pkg::lex_res_t                   res
);

  localparam int unsigned OW = sts_pkg::OFFSET_W;
  localparam int unsigned LW = sts_pkg::LINE_W;
  localparam int unsigned CW = sts_pkg::COL_W;
  localparam int unsigned TW = sts_pkg::TAB_W;

  logic          in_token_r, in_token_nxt;
  logic          prev_alnum_r, prev_alnum_nxt;
  logic [OW-1:0] byte_off_r, byte_off_nxt;
  logic [LW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [OW-1:0] tok_start_r, tok_start_nxt;
  logic [LW-1:0] tok_line_r, tok_line_nxt;
  logic [CW-1:0] tok_col_r, tok_col_nxt;
  logic          seen_r, seen_nxt;

  logic          b_alnum, b_space, b_sep, still_in;
  logic [7:0]    b;
  logic [OW-1:0] end_off, off_inc;
  logic [LW-1:0] line_inc;
  logic [CW-1:0] col_inc, col_tab;
  logic [CW:0]   col_tab_w;
  sts_pkg::out_item_t tok;

  assign b       = item.source_byte;
  assign b_alnum = sts_pkg::is_alnum(b);
  assign b_space = sts_pkg::is_space(b);
  assign b_sep   = b_space || sts_pkg::is_punct(b) || (b_alnum && !prev_alnum_r);
  assign still_in = in_token_r && !b_sep;

  assign end_off  = (byte_off_r != '0) ? byte_off_r - OW'(1) : '0;
  assign off_inc  = (byte_off_r == '1) ? byte_off_r : byte_off_r + OW'(1);
  assign line_inc = (line_r == '1) ? line_r : line_r + LW'(1);
  assign col_inc  = (col_r == '1) ? col_r : col_r + CW'(1);
  assign col_tab_w = {1'b0, col_r} + {{(CW + 1 - TW){1'b0}}, tab_step};
  assign col_tab  = col_tab_w[CW] ? '1 : col_tab_w[CW-1:0];

  always_comb begin
    tok.kind         = sts_pkg::KIND_TOKEN;
    tok.start_offset = tok_start_r;
    tok.end_offset   = end_off;
    tok.line         = tok_line_r;
    tok.column       = tok_col_r;
    tok.last         = 1'b0;
  end

  always_comb begin
    in_token_nxt   = in_token_r;
    prev_alnum_nxt = prev_alnum_r;
    byte_off_nxt   = byte_off_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    tok_start_nxt  = tok_start_r;
    tok_line_nxt   = tok_line_r;
    tok_col_nxt    = tok_col_r;
    seen_nxt       = seen_r;
    res.valid      = 1'b0;
    res.item       = tok;
    if (fire) begin
      if (item.op == sts_pkg::OP_END) begin
        res.valid = 1'b1;
        res.item.last = 1'b1;
        if (!in_token_r) begin
          res.item.kind         = seen_r ? sts_pkg::KIND_END : sts_pkg::KIND_EMPTY;
          res.item.start_offset = '0;
          res.item.end_offset   = '0;
          res.item.line         = '0;
          res.item.column       = '0;
        end
        in_token_nxt   = 1'b0;
        prev_alnum_nxt = 1'b0;
        byte_off_nxt   = '0;
        line_nxt       = LW'(1);
        col_nxt        = CW'(1);
        tok_start_nxt  = '0;
        tok_line_nxt   = LW'(1);
        tok_col_nxt    = CW'(1);
        seen_nxt       = 1'b0;
      end else begin
        res.valid    = in_token_r && b_sep;
        in_token_nxt = still_in;
        if (still_in) begin
          col_nxt = col_inc;
        end else if (b == sts_pkg::CH_NL) begin
          line_nxt = line_inc;
          col_nxt  = CW'(1);
        end else if (b == sts_pkg::CH_TAB) begin
          col_nxt = col_tab;
        end else if (b == sts_pkg::CH_SPACE) begin
          col_nxt = col_inc;
        end else begin
          in_token_nxt  = 1'b1;
          seen_nxt      = 1'b1;
          tok_start_nxt = byte_off_r;
          tok_line_nxt  = line_r;
          tok_col_nxt   = col_r;
          col_nxt       = col_inc;
        end
        byte_off_nxt   = off_inc;
        prev_alnum_nxt = b_alnum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r   <= 1'b0;
      prev_alnum_r <= 1'b0;
      byte_off_r   <= '0;
      line_r       <= LW'(1);
      col_r        <= CW'(1);
      tok_start_r  <= '0;
      tok_line_r   <= LW'(1);
      tok_col_r    <= CW'(1);
      seen_r       <= 1'b0;
    end else begin
      in_token_r   <= in_token_nxt;
      prev_alnum_r <= prev_alnum_nxt;
      byte_off_r   <= byte_off_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      tok_start_r  <= tok_start_nxt;
      tok_line_r   <= tok_line_nxt;
      tok_col_r    <= tok_col_nxt;
      seen_r       <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sts_out_stage.sv -----
`default_nettype none

module sts_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sts_pkg::lex_res_t  res,
  output logic                    up_free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sts_pkg::out_item_t      out_data
);

  logic               valid_r;
  logic               valid_nxt;
  sts_pkg::out_item_t data_r;

  assign up_free   = !valid_r || !out_stall;
  assign valid_nxt = res.valid || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res.item;
    end
  end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
  import sts_pkg::*;

  localparam longint unsigned OFS_TOP  = (64'd1 << OFFSET_W) - 1;
  localparam longint unsigned LINE_TOP = (64'd1 << LINE_W) - 1;
  localparam longint unsigned COL_TOP  = (64'd1 << COL_W) - 1;
  localparam logic [APB_AW-1:0] TAB_ADDR = APB_AW'(4 * REG_TAB_STEP);
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int N_PHASES     = 7;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int N_DIR = 26;
  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{'{OP_END,  8'h00},    1'b1, '{KIND_EMPTY, '0, '0, '0, '0, 1'b1}},
    '{'{OP_BYTE, "a"},      1'b0, '0},
    '{'{OP_BYTE, "b"},      1'b0, '0},
    '{'{OP_BYTE, CH_LPAR},  1'b1, '{KIND_TOKEN, 24'd0, 24'd1, 20'd1, 16'd1, 1'b0}},
    '{'{OP_BYTE, CH_RPAR},  1'b0, '0},
    '{'{OP_BYTE, CH_NL},    1'b0, '0},
    '{'{OP_BYTE, CH_TAB},   1'b0, '0},
    '{'{OP_BYTE, 8'hff},    1'b0, '0},
    '{'{OP_BYTE, 8'h80},    1'b0, '0},
    '{'{OP_BYTE, "9"},      1'b0, '0},
    '{'{OP_BYTE, "Z"},      1'b0, '0},
    '{'{OP_BYTE, CH_SPACE}, 1'b0, '0},
    '{'{OP_BYTE, CH_SEMI},  1'b0, '0},
    '{'{OP_BYTE, CH_RBRC},  1'b0, '0},
    '{'{OP_BYTE, CH_EQ},    1'b0, '0},
    '{'{OP_BYTE, CH_PCT},   1'b0, '0},
    '{'{OP_BYTE, "A"},      1'b0, '0},
    '{'{OP_END,  8'h00},    1'b0, '0},
    '{'{OP_BYTE, "x"},      1'b0, '0},
    '{'{OP_BYTE, CH_SPACE}, 1'b0, '0},
    '{'{OP_END,  8'hff},    1'b1, '{KIND_END, '0, '0, '0, '0, 1'b1}},
    '{'{OP_END,  8'h00},    1'b1, '{KIND_EMPTY, '0, '0, '0, '0, 1'b1}},
    '{'{OP_BYTE, "0"},      1'b0, '0},
    '{'{OP_BYTE, 8'h00},    1'b0, '0},
    '{'{OP_BYTE, "z"},      1'b0, '0},
    '{'{OP_END,  8'h00},    1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  int errors = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold = 1'b0;

  out_item_t tokens_due[$];

  // lexer state mirror
  logic [TAB_W-1:0]    tab_cols = TAB_RESET;
  bit                  tok_open, last_alnum, seen_tok;
  logic [OFFSET_W-1:0] pos, tok_pos;
  logic [LINE_W-1:0]   line_no, tok_line;
  logic [COL_W-1:0]    col_no, tok_col;

  source_token_splitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned top);
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic bit alnum_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic bit blank_char(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_NL;
  endfunction

  function automatic bit delim_char(input logic [7:0] b);
    return b == CH_LPAR || b == CH_RPAR || b == CH_SEMI || b == CH_LBRC ||
           b == CH_RBRC || b == CH_COMMA || b == CH_PLUS || b == CH_MINUS ||
           b == CH_STAR || b == CH_SLASH || b == CH_PCT || b == CH_EQ;
  endfunction

  function automatic void lexer_clear();
    tok_open = 1'b0;
    last_alnum = 1'b0;
    seen_tok = 1'b0;
    pos = '0;
    tok_pos = '0;
    line_no = LINE_W'(1);
    tok_line = LINE_W'(1);
    col_no = COL_W'(1);
    tok_col = COL_W'(1);
  endfunction

  function automatic out_item_t open_token(input logic fin);
    out_item_t t;
    t.kind = KIND_TOKEN;
    t.start_offset = tok_pos;
    t.end_offset = (pos != 0) ? pos - 1'b1 : '0;
    t.line = tok_line;
    t.column = tok_col;
    t.last = fin;
    return t;
  endfunction

  function automatic bit lex_step(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    bit hit;
    b = it.source_byte;
    hit = 1'b0;
    res = '0;
    if (it.op == OP_END) begin
      if (tok_open) begin
        res = open_token(1'b1);
      end else begin
        res.kind = seen_tok ? KIND_END : KIND_EMPTY;
        res.last = 1'b1;
      end
      lexer_clear();
      return 1'b1;
    end
    if (tok_open && (blank_char(b) || delim_char(b) || (alnum_char(b) && !last_alnum))) begin
      res = open_token(1'b0);
      hit = 1'b1;
      tok_open = 1'b0;
    end
    if (tok_open) begin
      col_no = COL_W'(sat_add(col_no, 1, COL_TOP));
    end else if (b == CH_NL) begin
      line_no = LINE_W'(sat_add(line_no, 1, LINE_TOP));
      col_no = COL_W'(1);
    end else if (b == CH_TAB) begin
      col_no = COL_W'(sat_add(col_no, tab_cols, COL_TOP));
    end else if (b == CH_SPACE) begin
      col_no = COL_W'(sat_add(col_no, 1, COL_TOP));
    end else begin
      tok_open = 1'b1;
      seen_tok = 1'b1;
      tok_pos = pos;
      tok_line = line_no;
      tok_col = col_no;
      col_no = COL_W'(sat_add(col_no, 1, COL_TOP));
    end
    pos = OFFSET_W'(sat_add(pos, 1, OFS_TOP));
    last_alnum = alnum_char(b);
    return hit;
  endfunction

  // mostly short runs, a few long ones
  function automatic int pace_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'($urandom_range("a", "z"));
    if (r < 32) return 8'($urandom_range("A", "Z"));
    if (r < 45) return 8'($urandom_range("0", "9"));
    if (r < 65) begin
      case ($urandom_range(0, 11))
        0: return CH_LPAR;
        1: return CH_RPAR;
        2: return CH_SEMI;
        3: return CH_LBRC;
        4: return CH_RBRC;
        5: return CH_COMMA;
        6: return CH_PLUS;
        7: return CH_MINUS;
        8: return CH_STAR;
        9: return CH_SLASH;
        10: return CH_PCT;
        default: return CH_EQ;
      endcase
    end
    if (r < 72) return CH_SPACE;
    if (r < 77) return CH_TAB;
    if (r < 82) return CH_NL;
    if (r < 88) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic cmp_field(input string name, input longint unsigned want,
                           input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // entered and left at a falling edge
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    int gap;
    out_item_t got;
    out_item_t due;
    gap = (tx_idle && $urandom_range(0, 1)) ? pace_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (lex_step(it, got)) begin
      due = typed ? want : got;
      tokens_due = {tokens_due, due};
    end
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item('{OP_BYTE, b}, 1'b0, '0);
  endtask

  task automatic send_end();
    send_item('{OP_END, 8'($urandom_range(0, 255))}, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic read_tab(input logic [TAB_W-1:0] w);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= TAB_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cmp_field("tab step readback", APB_DW'(w), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_tab_step(input logic [TAB_W-1:0] w);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TAB_ADDR;
    pwdata <= APB_DW'(w);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tab_cols = w;
    @(negedge clk);
    read_tab(w);
  endtask

  task automatic random_source(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1 || $urandom_range(0, 29) == 0) send_end();
      else send_byte(rand_char());
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got %h", $time, out_data);
      end else begin
        want = tokens_due.pop_front();
        cmp_field("kind", want.kind, out_data.kind);
        cmp_field("start_offset", want.start_offset, out_data.start_offset);
        cmp_field("end_offset", want.end_offset, out_data.end_offset);
        cmp_field("line", want.line, out_data.line);
        cmp_field("column", want.column, out_data.column);
        cmp_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin : rx_pace
    int run;
    logic hold;
    run = 0;
    hold = 1'b0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else if (long_hold) begin
        long_hold = 1'b0;
        hold = 1'b1;
        run = LONG_HOLD;
      end else if (!rx_idle) begin
        hold = 1'b0;
      end else begin
        hold = ($urandom_range(0, 3) == 0);
        run = pace_len();
      end
      out_stall <= hold;
    end
  end

  initial begin : stimulus
    logic [TAB_W-1:0] tab_plan [N_PHASES];
    tab_plan[0] = TAB_W'(0);
    tab_plan[1] = TAB_W'(1);
    tab_plan[2] = TAB_W'(16);
    tab_plan[3] = TAB_W'(31);
    tab_plan[4] = TAB_W'(17);
    tab_plan[5] = TAB_W'($urandom_range(1, 16));
    tab_plan[6] = TAB_W'($urandom_range(0, 31));
    lexer_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_tab(TAB_RESET);

    for (int k = 0; k < N_DIR; k++) send_item(DIR_TAB[k].item, DIR_TAB[k].typed, DIR_TAB[k].want);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      set_tab_step(tab_plan[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      random_source(70);
    end

    // receiver holds off while the sender keeps pushing
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    long_hold = 1'b1;
    for (int k = 0; k < 40; k++) send_byte(k % 3 == 2 ? CH_PLUS : rand_char());
    send_end();

    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sts_pkg.sv
hdl/sts_in_stage.sv
hdl/sts_lexer.sv
hdl/sts_out_stage.sv
hdl/source_token_splitter.sv
dv/testbench.sv
